// ----- hw/rtl/shapad_pkg.sv -----
`default_nettype none

package shapad_pkg;

  localparam int unsigned CountWidth = 61;
  localparam int unsigned WordWidth  = 32;
  localparam int unsigned IdxWidth   = 4;

  localparam logic [7:0]          PadByte  = 8'h80;
  localparam logic [IdxWidth-1:0] LenHiIdx = 4'd14;
  localparam logic [IdxWidth-1:0] LastIdx  = 4'd15;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } in_req_t;

  typedef struct packed {
    logic [WordWidth-1:0] out_word;
    logic                 block_end;
    logic                 final_word;
  } out_req_t;

  // Source of a padding word
  typedef enum logic [1:0] {
    SEL_PAD    = 2'd0,
    SEL_ZERO   = 2'd1,
    SEL_LEN_HI = 2'd2,
    SEL_LEN_LO = 2'd3
  } word_sel_e;

  typedef struct packed {
    logic      absorb;
    logic      emit;
    word_sel_e sel;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic last_zero;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/shapad_dp.sv -----
`default_nettype none

module shapad_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  shapad_pkg::in_req_t    in_req_i,
  input  shapad_pkg::dp_cmd_t    cmd_i,
  output shapad_pkg::dp_status_t status_o,
  input  logic                   out_stall_i,
  output logic                   out_valid_o,
  output shapad_pkg::out_req_t   out_req_o
);
  import shapad_pkg::*;

  logic [CountWidth-1:0] count_q, count_d;
  logic [23:0]           partial_q, partial_d;
  logic [IdxWidth-1:0]   widx_q, widx_d;
  logic                  out_valid_q, out_valid_d;
  out_req_t              out_q, out_d;

  logic                  out_free;
  logic [IdxWidth-1:0]   cur_idx;
  logic [IdxWidth-1:0]   next_idx;
  logic [WordWidth-1:0]  pad_word;

  assign out_free = !out_valid_q || !out_stall_i;
  // the 0x80 word starts at the word the message ends in
  assign cur_idx  = (cmd_i.sel == SEL_PAD) ? count_q[5:2] : widx_q;
  assign next_idx = cur_idx + 4'd1;
  // left-align the unfinished bytes with the marker byte behind them
  assign pad_word = {partial_q, PadByte} << {~count_q[1:0], 3'b000};

  assign status_o.out_free  = out_free;
  assign status_o.last_zero = (next_idx == LenHiIdx);

  always_comb begin
    count_d     = count_q;
    partial_d   = partial_q;
    widx_d      = widx_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    if (cmd_i.absorb && in_req_i.has_byte) begin
      count_d = count_q + 61'd1;
      if (count_q[1:0] == 2'd3) begin
        out_valid_d         = 1'b1;
        out_d.out_word      = {partial_q, in_req_i.data_byte};
        out_d.block_end     = (count_q[5:0] == 6'd63);
        out_d.final_word    = 1'b0;
        partial_d           = '0;
      end else begin
        partial_d = {partial_q[15:0], in_req_i.data_byte};
      end
    end

    if (cmd_i.emit) begin
      out_valid_d      = 1'b1;
      widx_d           = next_idx;
      out_d.block_end  = (cur_idx == LastIdx);
      out_d.final_word = 1'b0;
      unique case (cmd_i.sel)
        SEL_PAD:    out_d.out_word = pad_word;
        SEL_ZERO:   out_d.out_word = '0;
        SEL_LEN_HI: out_d.out_word = count_q[60:29];
        SEL_LEN_LO: begin
          out_d.out_word   = {count_q[28:0], 3'b000};
          out_d.final_word = 1'b1;
          count_d          = '0;
          partial_d        = '0;
        end
        default:    out_d.out_word = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      partial_q   <= '0;
      widx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      partial_q   <= partial_d;
      widx_q      <= widx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  a_final_ends_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.final_word |-> out_q.block_end)
    else $error("final word not at block end");

  a_final_clears_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.final_word |-> count_q == '0 && partial_q == '0)
    else $error("message state not cleared with final word");

  a_len_hi_place: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit && cmd_i.sel == SEL_LEN_HI |-> cur_idx == LenHiIdx)
    else $error("length word out of place");

  a_len_lo_place: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit && cmd_i.sel == SEL_LEN_LO |-> cur_idx == LastIdx)
    else $error("low length word out of place");

endmodule

`default_nettype wire

// ----- hw/rtl/shapad_ctrl.sv -----
`default_nettype none

module shapad_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_end_i,
  output logic                   in_stall_o,
  input  shapad_pkg::dp_status_t status_i,
  output shapad_pkg::dp_cmd_t    cmd_o
);
  import shapad_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_PAD    = 5'b00010,
    ST_ZERO   = 5'b00100,
    ST_LEN_HI = 5'b01000,
    ST_LEN_LO = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   take;

  assign in_stall_o = !((state_q == ST_IDLE) && status_i.out_free);
  assign take       = in_valid_i && !in_stall_o;

  always_comb begin
    state_d      = state_q;
    cmd_o.absorb = 1'b0;
    cmd_o.emit   = 1'b0;
    cmd_o.sel    = SEL_ZERO;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.absorb = take;
        if (take && in_end_i) begin
          state_d = ST_PAD;
        end
      end
      ST_PAD: begin
        cmd_o.sel  = SEL_PAD;
        cmd_o.emit = status_i.out_free;
        if (status_i.out_free) begin
          state_d = status_i.last_zero ? ST_LEN_HI : ST_ZERO;
        end
      end
      ST_ZERO: begin
        cmd_o.sel  = SEL_ZERO;
        cmd_o.emit = status_i.out_free;
        if (status_i.out_free && status_i.last_zero) begin
          state_d = ST_LEN_HI;
        end
      end
      ST_LEN_HI: begin
        cmd_o.sel  = SEL_LEN_HI;
        cmd_o.emit = status_i.out_free;
        if (status_i.out_free) begin
          state_d = ST_LEN_LO;
        end
      end
      ST_LEN_LO: begin
        cmd_o.sel  = SEL_LEN_LO;
        cmd_o.emit = status_i.out_free;
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/sha256_message_padder.sv -----
// A word completed by a message byte is registered and on the output in the cycle after its request is taken.
// Throughput: byte requests are taken one per cycle while the output is not stalled.
// An end-of-message request holds the input off while the 3 to 18 padding words
// leave, one per cycle while the output is not stalled; the padding sequencer in the controller sets that figure.
// Reset (asynchronous, active low) clears the byte count, the unfinished word,
// the sequencer and the output valid; the block is then ready for a new message.
`default_nettype none

module sha256_message_padder (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // message byte requests
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  shapad_pkg::in_req_t  in_req_i,
  // padded word requests
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output shapad_pkg::out_req_t out_req_o
);
  import shapad_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequence the padding: 0x80 word, zero words up to word 14 of the block,
  // then the two halves of the 64-bit bit length.
  shapad_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_end_i   (in_req_i.end_of_message),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Hold the byte count, pack bytes into words, form the padding words, and drive the output register.
  shapad_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_req_o   (out_req_o)
  );

endmodule

`default_nettype wire
